/* design/sgp_pkg.sv */
package sgp_pkg;

    // field widths
    localparam int CODE_W    = 8;
    localparam int COLOR_W   = 16;
    localparam int SCALE_W   = 2;
    localparam int COL_W     = 3;
    localparam int ROW_W     = 3;
    localparam int CFG_IDX_W = 2;
    localparam int GLYPH_COLS = 5;
    localparam int GLYPH_ROWS = 7;

    // scale limit default
    localparam int DEF_MAX_SCALE = 3;

    // item operations
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_PULL = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FORE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BACK  = 2'd2;

    // register reset values
    localparam logic [SCALE_W-1:0] SCALE_RST = 2'd1;
    localparam logic [COLOR_W-1:0] FORE_RST  = 16'hFFFF;
    localparam logic [COLOR_W-1:0] BACK_RST  = 16'h0000;

    // last column and last row of the glyph cell
    localparam logic [COL_W-1:0] COL_LAST = 3'd4;
    localparam logic [ROW_W-1:0] ROW_LAST = 3'd6;

    typedef logic [GLYPH_ROWS-1:0] glyph_col_t;
    typedef glyph_col_t [GLYPH_COLS-1:0] glyph_t;

    // scan position handed from the counters to the glyph store and output
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             gap;
        logic             window_last;
        logic             char_last;
    } scan_pos_t;

    // 5x7 font, one byte per column, bit 0 is the top row;
    // codes outside the printable range fall to the question mark
    function automatic glyph_t font_lookup(input logic [CODE_W-1:0] code);
        logic [39:0] w;
        glyph_t      g;
        unique case (code)
            8'h20: w = 40'h0000000000;  8'h21: w = 40'h00005F0000;
            8'h22: w = 40'h0007000700;  8'h23: w = 40'h147F147F14;
            8'h24: w = 40'h242A7F2A12;  8'h25: w = 40'h2313086462;
            8'h26: w = 40'h3649552250;  8'h27: w = 40'h0005030000;
            8'h28: w = 40'h001C224100;  8'h29: w = 40'h0041221C00;
            8'h2A: w = 40'h14083E0814;  8'h2B: w = 40'h08083E0808;
            8'h2C: w = 40'h0050300000;  8'h2D: w = 40'h0808080808;
            8'h2E: w = 40'h0060600000;  8'h2F: w = 40'h2010080402;
            8'h30: w = 40'h3E5149453E;  8'h31: w = 40'h00427F4000;
            8'h32: w = 40'h4261514946;  8'h33: w = 40'h2141454B31;
            8'h34: w = 40'h1814127F10;  8'h35: w = 40'h2745454539;
            8'h36: w = 40'h3C4A494930;  8'h37: w = 40'h0171090503;
            8'h38: w = 40'h3649494936;  8'h39: w = 40'h064949291E;
            8'h3A: w = 40'h0036360000;  8'h3B: w = 40'h0056360000;
            8'h3C: w = 40'h0814224100;  8'h3D: w = 40'h1414141414;
            8'h3E: w = 40'h0041221408;  8'h3F: w = 40'h0201510906;
            8'h40: w = 40'h324979413E;  8'h41: w = 40'h7E1111117E;
            8'h42: w = 40'h7F49494936;  8'h43: w = 40'h3E41414122;
            8'h44: w = 40'h7F4141221C;  8'h45: w = 40'h7F49494941;
            8'h46: w = 40'h7F09090901;  8'h47: w = 40'h3E4149497A;
            8'h48: w = 40'h7F0808087F;  8'h49: w = 40'h00417F4100;
            8'h4A: w = 40'h2040413F01;  8'h4B: w = 40'h7F08142241;
            8'h4C: w = 40'h7F40404040;  8'h4D: w = 40'h7F020C027F;
            8'h4E: w = 40'h7F0408107F;  8'h4F: w = 40'h3E4141413E;
            8'h50: w = 40'h7F09090906;  8'h51: w = 40'h3E4151215E;
            8'h52: w = 40'h7F09192946;  8'h53: w = 40'h4649494931;
            8'h54: w = 40'h01017F0101;  8'h55: w = 40'h3F4040403F;
            8'h56: w = 40'h1F2040201F;  8'h57: w = 40'h3F4038403F;
            8'h58: w = 40'h6314081463;  8'h59: w = 40'h0708700807;
            8'h5A: w = 40'h6151494543;  8'h5B: w = 40'h007F414100;
            8'h5C: w = 40'h0204081020;  8'h5D: w = 40'h0041417F00;
            8'h5E: w = 40'h0402010204;  8'h5F: w = 40'h4040404040;
            8'h60: w = 40'h0001020400;  8'h61: w = 40'h2054545478;
            8'h62: w = 40'h7F48444438;  8'h63: w = 40'h3844444420;
            8'h64: w = 40'h384444487F;  8'h65: w = 40'h3854545418;
            8'h66: w = 40'h087E090102;  8'h67: w = 40'h0C5252523E;
            8'h68: w = 40'h7F08040478;  8'h69: w = 40'h00447D4000;
            8'h6A: w = 40'h2040443D00;  8'h6B: w = 40'h7F10284400;
            8'h6C: w = 40'h00417F4000;  8'h6D: w = 40'h7C04180478;
            8'h6E: w = 40'h7C08040478;  8'h6F: w = 40'h3844444438;
            8'h70: w = 40'h7C14141408;  8'h71: w = 40'h081414187C;
            8'h72: w = 40'h7C08040408;  8'h73: w = 40'h4854545420;
            8'h74: w = 40'h043F444020;  8'h75: w = 40'h3C4040403C;
            8'h76: w = 40'h1C2040201C;  8'h77: w = 40'h3C4030403C;
            8'h78: w = 40'h4428102844;  8'h79: w = 40'h0C5050503E;
            8'h7A: w = 40'h4464544C44;  8'h7B: w = 40'h0008364100;
            8'h7C: w = 40'h00007F0000;  8'h7D: w = 40'h0041360800;
            8'h7E: w = 40'h1008081008;
            default: w = 40'h0201510906;
        endcase
        for (int i = 0; i < GLYPH_COLS; i++) begin
            g[i] = w[38 - 8*i -: GLYPH_ROWS];
        end
        return g;
    endfunction

endpackage

/* design/sgp_glyph_store.sv */
module sgp_glyph_store
    import sgp_pkg::*;
(
    input  logic              aclk,
    input  logic              load_en,
    input  logic [CODE_W-1:0] char_code,
    input  scan_pos_t         pos,
    output logic              font_bit
);

    glyph_t           glyph_reg;
    glyph_t           glyph_next;
    logic [COL_W-1:0] col_sel;
    logic [ROW_W-1:0] row_sel;

    // latch the glyph columns on a load
    always_comb begin
        glyph_next = load_en ? font_lookup(char_code) : glyph_reg;
    end

    always_ff @(posedge aclk) begin
        glyph_reg <= glyph_next;
    end

    // pick the bit under the scan position, clamped into the cell
    always_comb begin
        col_sel  = (pos.col > COL_LAST) ? COL_LAST : pos.col;
        row_sel  = (pos.row > ROW_LAST) ? ROW_LAST : pos.row;
        font_bit = glyph_reg[col_sel][row_sel];
    end

endmodule

/* design/sgp_scan_ctrl.sv */
module sgp_scan_ctrl
    import sgp_pkg::*;
#(
    parameter int MAX_SCALE = DEF_MAX_SCALE
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load_en,
    input  logic               pull_en,
    input  logic [SCALE_W-1:0] scale_factor,
    output logic               busy,
    output scan_pos_t          pos
);

    // largest repeat index allowed by the scale limit
    localparam logic [SCALE_W-1:0] MAX_LIM =
        (MAX_SCALE > 3) ? 2'd2 : SCALE_W'(MAX_SCALE - 1);

    logic [SCALE_W-1:0] subcol_reg, subcol_next;
    logic [SCALE_W-1:0] subrow_reg, subrow_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic               gap_reg, gap_next;
    logic               busy_reg, busy_next;

    logic [SCALE_W-1:0] lim;
    logic               sc_end, sr_end, col_end, row_end;

    // effective scale minus one
    always_comb begin
        if (scale_factor == '0) begin
            lim = '0;
        end else if ((scale_factor - 2'd1) > MAX_LIM) begin
            lim = MAX_LIM;
        end else begin
            lim = scale_factor - 2'd1;
        end
    end

    assign sc_end  = subcol_reg >= lim;
    assign sr_end  = subrow_reg >= lim;
    assign col_end = col_reg >= COL_LAST;
    assign row_end = row_reg >= ROW_LAST;

    // scan position and end flags for the current pull
    always_comb begin
        pos.col         = col_reg;
        pos.row         = row_reg;
        pos.gap         = gap_reg;
        pos.window_last = sc_end && sr_end && row_end && (gap_reg || col_end);
        pos.char_last   = gap_reg && sc_end && sr_end && row_end;
    end

    // counter advance
    always_comb begin
        subcol_next = subcol_reg;
        subrow_next = subrow_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        gap_next    = gap_reg;
        busy_next   = busy_reg;
        if (load_en && !busy_reg) begin
            subcol_next = '0;
            subrow_next = '0;
            col_next    = '0;
            row_next    = '0;
            gap_next    = 1'b0;
            busy_next   = 1'b1;
        end else if (pull_en && busy_reg) begin
            if (!sc_end) begin
                subcol_next = subcol_reg + 2'd1;
            end else begin
                subcol_next = '0;
                if (!gap_reg && !col_end) begin
                    col_next = col_reg + 3'd1;
                end else begin
                    col_next = '0;
                    if (!sr_end) begin
                        subrow_next = subrow_reg + 2'd1;
                    end else begin
                        subrow_next = '0;
                        if (!row_end) begin
                            row_next = row_reg + 3'd1;
                        end else begin
                            row_next = '0;
                            gap_next = !gap_reg;
                            if (gap_reg) begin
                                busy_next = 1'b0;
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            subcol_reg <= '0;
            subrow_reg <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            gap_reg    <= 1'b0;
            busy_reg   <= 1'b0;
        end else begin
            subcol_reg <= subcol_next;
            subrow_reg <= subrow_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            gap_reg    <= gap_next;
            busy_reg   <= busy_next;
        end
    end

    assign busy = busy_reg;

endmodule

/* design/scaled_glyph_pixel_generator.sv */
// channel   direction  ports                                             role
// s_        in         s_valid s_ready s_op s_char_code                  load / pull word
// m_        out        m_valid m_ready m_pixel_color m_in_gap            pixel word
//                      m_window_last m_char_last
// cfg_      in         cfg_we cfg_index cfg_wdata                        register write
//
// one input word per cycle while s_ready is high; a pull while busy yields its pixel in the next cycle
// the glyph ROM lookup, the scan counters and the color select sit between the
// accepted word and the output register
// s_ready is low only while the output register holds a word that m_ready refuses
// synchronous active-low reset returns the block to idle with default registers
module scaled_glyph_pixel_generator
    import sgp_pkg::*;
#(
    parameter int MAX_SCALE = DEF_MAX_SCALE
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_op,
    input  logic [CODE_W-1:0]    s_char_code,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [COLOR_W-1:0]   m_pixel_color,
    output logic                 m_in_gap,
    output logic                 m_window_last,
    output logic                 m_char_last,

    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COLOR_W-1:0]   cfg_wdata
);

    logic [SCALE_W-1:0] scale_reg;
    logic [COLOR_W-1:0] fore_reg;
    logic [COLOR_W-1:0] back_reg;

    logic               m_valid_reg, m_valid_next;
    logic [COLOR_W-1:0] pixel_reg, pixel_next;
    logic               gap_reg, wlast_reg, clast_reg;

    logic      s_fire, load_en, pull_en, pull_out, busy, font_bit;
    scan_pos_t pos;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= SCALE_RST;
            fore_reg  <= FORE_RST;
            back_reg  <= BACK_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_SCALE: scale_reg <= cfg_wdata[SCALE_W-1:0];
                CFG_FORE:  fore_reg  <= cfg_wdata;
                CFG_BACK:  back_reg  <= cfg_wdata;
                default:   ;
            endcase
        end
    end

    // input handshake
    assign s_ready  = !m_valid_reg || m_ready;
    assign s_fire   = s_valid && s_ready;
    assign load_en  = s_fire && (s_op == OP_LOAD);
    assign pull_en  = s_fire && (s_op == OP_PULL);
    assign pull_out = pull_en && busy;

    sgp_scan_ctrl #(
        .MAX_SCALE(MAX_SCALE)
    ) u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load_en     (load_en),
        .pull_en     (pull_en),
        .scale_factor(scale_reg),
        .busy        (busy),
        .pos         (pos)
    );

    sgp_glyph_store u_glyph (
        .aclk     (aclk),
        .load_en  (load_en && !busy),
        .char_code(s_char_code),
        .pos      (pos),
        .font_bit (font_bit)
    );

    // pixel color select
    assign pixel_next = (!pos.gap && font_bit) ? fore_reg : back_reg;

    // output word valid
    always_comb begin
        if (pull_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // output word payload
    always_ff @(posedge aclk) begin
        if (pull_out) begin
            pixel_reg <= pixel_next;
            gap_reg   <= pos.gap;
            wlast_reg <= pos.window_last;
            clast_reg <= pos.char_last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_pixel_color = pixel_reg;
    assign m_in_gap      = gap_reg;
    assign m_window_last = wlast_reg;
    assign m_char_last   = clast_reg;

endmodule

/* sim/sgp_pixel_checker.sv */
module sgp_pixel_checker
    import sgp_pkg::*;
#(
    parameter int MAX_SCALE = DEF_MAX_SCALE
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic                 s_op,
    input  logic [CODE_W-1:0]    s_char_code,

    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [COLOR_W-1:0]   m_pixel_color,
    input  logic                 m_in_gap,
    input  logic                 m_window_last,
    input  logic                 m_char_last,

    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COLOR_W-1:0]   cfg_wdata,

    output int                   mismatch_count,
    output int                   words_outstanding,
    output int                   pixels_checked
);

    localparam int FIRST_CODE    = 'h20;
    localparam int LAST_CODE     = 'h7E;
    localparam int QUESTION_MARK = 'h3F;
    localparam int FONT_GLYPHS   = LAST_CODE - FIRST_CODE + 1;
    localparam int MAX_PRINTED   = 40;

    // font, one 40-bit entry per printable code starting at space,
    // five column bytes left to right, bit 0 of a byte is the top row
    localparam logic [FONT_GLYPHS*40-1:0] FONT_BITS = {
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14, 40'h242A7F2A12,
        40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001C224100, 40'h0041221C00,
        40'h14083E0814, 40'h08083E0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
        40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503, 40'h3649494936,
        40'h064949291E, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
        40'h0041221408, 40'h0201510906, 40'h324979413E, 40'h7E1111117E, 40'h7F49494936,
        40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
        40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
        40'h7F09192946, 40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
        40'h3F4038403F, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
        40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040, 40'h0001020400,
        40'h2054545478, 40'h7F48444438, 40'h3844444420, 40'h384444487F, 40'h3854545418,
        40'h087E090102, 40'h0C5252523E, 40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
        40'h7F10284400, 40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
        40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420, 40'h043F444020,
        40'h3C4040403C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h0C5050503E,
        40'h4464544C44, 40'h0008364100, 40'h00007F0000, 40'h0041360800, 40'h1008081008
    };

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic               gap;
        logic               win_last;
        logic               chr_last;
    } pixel_word_t;

    pixel_word_t expected_pixels[$];

    // register copy
    logic [SCALE_W-1:0] scale_r;
    logic [COLOR_W-1:0] fore_r;
    logic [COLOR_W-1:0] back_r;

    // latched glyph and scan position
    glyph_col_t glyph_cols [GLYPH_COLS];
    int         row_q;
    int         subrow_q;
    int         col_q;
    int         subcol_q;
    bit         gap_q;
    bit         busy_q;

    // one column of the glyph for a code, unknown codes show the question mark
    function automatic glyph_col_t font_column(input logic [CODE_W-1:0] code, input int col);
        int glyph;
        if (code < FIRST_CODE || code > LAST_CODE) begin
            glyph = QUESTION_MARK - FIRST_CODE;
        end else begin
            glyph = int'(code) - FIRST_CODE;
        end
        return FONT_BITS[(FONT_GLYPHS - 1 - glyph) * 40 + (GLYPH_COLS - 1 - col) * 8 +:
                         GLYPH_ROWS];
    endfunction

    // next pixel of the scan and the counter advance behind it
    task automatic predict_pixel(output pixel_word_t w);
        int s;
        int c;
        int r;
        bit sc_end;
        bit sr_end;
        bit row_end;
        bit col_end;
        s = (scale_r == 0) ? 1 : ((int'(scale_r) > MAX_SCALE) ? MAX_SCALE : int'(scale_r));
        sc_end  = (subcol_q >= s - 1);
        sr_end  = (subrow_q >= s - 1);
        row_end = (row_q >= ROW_LAST);
        if (!gap_q) begin
            col_end = (col_q >= COL_LAST);
            c = (col_q > COL_LAST) ? COL_LAST : col_q;
            r = (row_q > ROW_LAST) ? ROW_LAST : row_q;
            w.color    = glyph_cols[c][r] ? fore_r : back_r;
            w.gap      = 1'b0;
            w.win_last = sc_end && col_end && sr_end && row_end;
            w.chr_last = 1'b0;
            if (!sc_end) begin
                subcol_q++;
            end else begin
                subcol_q = 0;
                if (!col_end) begin
                    col_q++;
                end else begin
                    col_q = 0;
                    if (!sr_end) begin
                        subrow_q++;
                    end else begin
                        subrow_q = 0;
                        if (!row_end) begin
                            row_q++;
                        end else begin
                            row_q = 0;
                            gap_q = 1'b1;
                        end
                    end
                end
            end
        end else begin
            // gap window: one column group of background, then idle
            w.color    = back_r;
            w.gap      = 1'b1;
            w.win_last = sc_end && sr_end && row_end;
            w.chr_last = w.win_last;
            if (!sc_end) begin
                subcol_q++;
            end else begin
                subcol_q = 0;
                if (!sr_end) begin
                    subrow_q++;
                end else begin
                    subrow_q = 0;
                    if (!row_end) begin
                        row_q++;
                    end else begin
                        row_q  = 0;
                        gap_q  = 1'b0;
                        busy_q = 1'b0;
                    end
                end
            end
        end
    endtask

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED) begin
            $display("mismatch at pixel %0d: %s", pixels_checked, msg);
        end
    endtask

    // compare outgoing words, track register writes, predict from incoming words
    always @(posedge aclk) begin
        pixel_word_t want;
        pixel_word_t next;
        if (!aresetn) begin
            scale_r  = SCALE_RST;
            fore_r   = FORE_RST;
            back_r   = BACK_RST;
            for (int i = 0; i < GLYPH_COLS; i++) begin
                glyph_cols[i] = '0;
            end
            row_q    = 0;
            subrow_q = 0;
            col_q    = 0;
            subcol_q = 0;
            gap_q    = 1'b0;
            busy_q   = 1'b0;
            expected_pixels.delete();
        end else begin
            // outgoing pixel word against the oldest prediction
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch($sformatf("unexpected word color %h", m_pixel_color));
                end else begin
                    want = expected_pixels.pop_front();
                    if (m_pixel_color !== want.color) begin
                        report_mismatch($sformatf("color %h want %h", m_pixel_color,
                                                  want.color));
                    end
                    if (m_in_gap !== want.gap) begin
                        report_mismatch($sformatf("in_gap %b want %b", m_in_gap, want.gap));
                    end
                    if (m_window_last !== want.win_last) begin
                        report_mismatch($sformatf("window_last %b want %b", m_window_last,
                                                  want.win_last));
                    end
                    if (m_char_last !== want.chr_last) begin
                        report_mismatch($sformatf("char_last %b want %b", m_char_last,
                                                  want.chr_last));
                    end
                end
                pixels_checked++;
            end

            // register writes
            if (cfg_we) begin
                case (cfg_index)
                    CFG_SCALE: scale_r = cfg_wdata[SCALE_W-1:0];
                    CFG_FORE:  fore_r  = cfg_wdata;
                    CFG_BACK:  back_r  = cfg_wdata;
                    default: ;
                endcase
            end

            // incoming word: load latches a glyph when idle, pull yields a pixel when busy
            if (s_valid && s_ready) begin
                if (s_op == OP_LOAD) begin
                    if (!busy_q) begin
                        for (int i = 0; i < GLYPH_COLS; i++) begin
                            glyph_cols[i] = font_column(s_char_code, i);
                        end
                        row_q    = 0;
                        subrow_q = 0;
                        col_q    = 0;
                        subcol_q = 0;
                        gap_q    = 1'b0;
                        busy_q   = 1'b1;
                    end
                end else if (busy_q) begin
                    predict_pixel(next);
                    expected_pixels.push_back(next);
                end
            end
        end
        words_outstanding = expected_pixels.size();
    end

endmodule

/* sim/tb_scaled_glyph_pixel_generator.sv */
module tb_scaled_glyph_pixel_generator;
    import sgp_pkg::*;

    localparam int MAX_SCALE        = DEF_MAX_SCALE;
    localparam int RESET_CYCLES     = 11;
    localparam int SETTLE_CYCLES    = 4;
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int PHASES           = 4;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 s_valid       = 1'b0;
    logic                 s_ready;
    logic                 s_op          = OP_LOAD;
    logic [CODE_W-1:0]    s_char_code   = '0;
    logic                 m_valid;
    logic                 m_ready       = 1'b0;
    logic [COLOR_W-1:0]   m_pixel_color;
    logic                 m_in_gap;
    logic                 m_window_last;
    logic                 m_char_last;
    logic                 cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index     = CFG_SCALE;
    logic [COLOR_W-1:0]   cfg_wdata     = '0;

    int mismatch_count;
    int words_outstanding;
    int pixels_checked;

    // flow control knobs
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int holds_served   = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;

    int                 loads_sent = 0;
    int                 pulls_sent = 0;
    logic [SCALE_W-1:0] scale_now  = SCALE_RST;

    scaled_glyph_pixel_generator #(
        .MAX_SCALE (MAX_SCALE)
    ) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_char_code   (s_char_code),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_color (m_pixel_color),
        .m_in_gap      (m_in_gap),
        .m_window_last (m_window_last),
        .m_char_last   (m_char_last),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    sgp_pixel_checker #(
        .MAX_SCALE (MAX_SCALE)
    ) pixel_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_op              (s_op),
        .s_char_code       (s_char_code),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_pixel_color     (m_pixel_color),
        .m_in_gap          (m_in_gap),
        .m_window_last     (m_window_last),
        .m_char_last       (m_char_last),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .mismatch_count    (mismatch_count),
        .words_outstanding (words_outstanding),
        .pixels_checked    (pixels_checked)
    );

    // clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge aclk) begin
        if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            hold_left    = LONG_HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog on handshake activity
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    // pulls that one character takes at a given scale register value
    function automatic int char_pulls(input logic [SCALE_W-1:0] scale);
        int s;
        s = (scale == 0) ? 1 : ((int'(scale) > MAX_SCALE) ? MAX_SCALE : int'(scale));
        return GLYPH_ROWS * (GLYPH_COLS + 1) * s * s;
    endfunction

    // mostly printable codes, with range edges and codes outside the font
    function automatic logic [CODE_W-1:0] random_code();
        int pick;
        pick = $urandom_range(99);
        if (pick < 8) begin
            case ($urandom_range(3))
                0:       return 8'h1F;
                1:       return 8'h20;
                2:       return 8'h7E;
                default: return 8'h7F;
            endcase
        end else if (pick < 14) begin
            return CODE_W'($urandom_range(8'h1F, 8'h00));
        end else if (pick < 22) begin
            return CODE_W'($urandom_range(8'hFF, 8'h7F));
        end
        return CODE_W'($urandom_range(8'h7E, 8'h20));
    endfunction

    // offer one input word, called at a falling edge, returns at a falling edge
    task automatic send_word(input logic op, input logic [CODE_W-1:0] code);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_op        <= op;
        s_char_code <= code;
        do @(posedge aclk); while (s_ready !== 1'b1);
        if (op == OP_LOAD) loads_sent++;
        else pulls_sent++;
        @(negedge aclk);
    endtask

    // drop valid and let every predicted word come out
    task automatic drain_block();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (words_outstanding != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // write all three registers back to back, block idle
    task automatic write_config(input logic [SCALE_W-1:0] scale,
                                input logic [COLOR_W-1:0] fore,
                                input logic [COLOR_W-1:0] back);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SCALE;
        cfg_wdata <= {{(COLOR_W-SCALE_W){1'b0}}, scale};
        @(negedge aclk);
        cfg_index <= CFG_FORE;
        cfg_wdata <= fore;
        @(negedge aclk);
        cfg_index <= CFG_BACK;
        cfg_wdata <= back;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        @(negedge aclk);
        scale_now = scale;
    endtask

    // one whole character, with the odd load dropped while busy
    task automatic run_char(input logic [CODE_W-1:0] code);
        int pulls;
        pulls = char_pulls(scale_now);
        send_word(OP_LOAD, code);
        for (int i = 0; i < pulls; i++) begin
            if ($urandom_range(19) == 0) send_word(OP_LOAD, random_code());
            send_word(OP_PULL, CODE_W'($urandom_range(255)));
        end
    endtask

    initial begin
        int                 budget;
        int                 phase_start;
        logic [SCALE_W-1:0] scale;
        logic [COLOR_W-1:0] fore;
        logic [COLOR_W-1:0] back;

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: reset registers, pulls while idle, low code, loads while busy
        send_word(OP_PULL, 8'hFF);
        send_word(OP_PULL, 8'h00);
        send_word(OP_LOAD, 8'h00);
        send_word(OP_LOAD, 8'h7E);
        for (int i = 0; i < char_pulls(scale_now); i++) begin
            if (i == 20) send_word(OP_LOAD, 8'hFF);
            send_word(OP_PULL, CODE_W'($urandom_range(255)));
        end
        send_word(OP_PULL, 8'hAA);
        drain_block();

        // random phases, each with its own register setting and flow-control mix
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    send_idle_pct = 0;  recv_stall_pct = 0;
                    scale = 2'd3; fore = 16'h0000; back = 16'hFFFF; budget = 1;
                end
                1: begin
                    send_idle_pct = 79; recv_stall_pct = 0;
                    scale = 2'd0; fore = COLOR_W'($urandom_range(16'hFFFF));
                    back = COLOR_W'($urandom_range(16'hFFFF)); budget = 1;
                end
                2: begin
                    send_idle_pct = 0;  recv_stall_pct = 79;
                    scale = 2'd1; fore = 16'hFFFF; back = 16'h0000; budget = 1;
                end
                default: begin
                    send_idle_pct = 28; recv_stall_pct = 28;
                    scale = 2'd1; fore = COLOR_W'($urandom_range(16'hFFFF));
                    back = COLOR_W'($urandom_range(16'hFFFF)); budget = 1;
                end
            endcase
            write_config(scale, fore, back);
            phase_start = loads_sent + pulls_sent;
            // long receiver hold-off while pulls keep coming
            if (p == 0) hold_requests++;
            while (loads_sent + pulls_sent - phase_start < budget) begin
                if ($urandom_range(3) == 0) send_word(OP_PULL, CODE_W'($urandom_range(255)));
                run_char(random_code());
            end
            drain_block();
        end

        $display("covered %0d loads and %0d pulls, %0d pixel words compared",
                 loads_sent, pulls_sent, pixels_checked);
        $display("scale settings 0, 1 and 3, color extremes, stalls on both sides");
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/sgp_pkg.sv
design/sgp_glyph_store.sv
design/sgp_scan_ctrl.sv
design/scaled_glyph_pixel_generator.sv
sim/sgp_pixel_checker.sv
sim/tb_scaled_glyph_pixel_generator.sv
